@@ hw/rtl/cir_pkg.sv @@
// shared types, constants and helpers for the contact impulse resolver
package cir_pkg;

  localparam int VEL_W   = 32;
  localparam int NRM_W   = 18;
  localparam int BNC_W   = 17;
  localparam int IM_W    = 31;
  localparam int DIFF_W  = VEL_W + 1;
  localparam int PROD_W  = DIFF_W + NRM_W;
  localparam int VN_W    = PROD_W + 2;
  localparam int NEG_W   = 36;
  localparam int FAC_W   = 18;
  localparam int NUM_W   = NEG_W + FAC_W;
  localparam int SUM_W   = IM_W + 1;
  localparam int DIV_STEPS = NUM_W;
  localparam int JP_W    = NRM_W + VEL_W;
  localparam int DV_W    = VEL_W + VEL_W;
  localparam int FRAC    = 16;
  localparam logic [FAC_W-1:0] ONE_Q16 = FAC_W'(65536);
  localparam logic [IM_W-1:0]  J_MAX   = {IM_W{1'b1}};

  typedef enum logic [1:0] {
    OUT_IMPULSE  = 2'd0,
    OUT_SEPARATE = 2'd1,
    OUT_STATIC   = 2'd2
  } outcome_t;

  // per-contact context carried down the pipeline
  typedef struct packed {
    logic [2:0][VEL_W-1:0] va;
    logic [2:0][VEL_W-1:0] vb;
    logic [2:0][NRM_W-1:0] n;
    logic [IM_W-1:0]       ima;
    logic [IM_W-1:0]       imb;
    outcome_t              outcome;
  } ctx_t;

  // clamp to signed 32 bit
  function automatic logic [VEL_W-1:0] sat32(input logic signed [63:0] x);
    logic [VEL_W-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cir_in_if.sv @@
// contact word channel
interface cir_in_if;
  logic                          valid;
  logic                          ready;
  logic [cir_pkg::VEL_W-1:0]     vel_a_x;
  logic [cir_pkg::VEL_W-1:0]     vel_a_y;
  logic [cir_pkg::VEL_W-1:0]     vel_a_z;
  logic [cir_pkg::VEL_W-1:0]     vel_b_x;
  logic [cir_pkg::VEL_W-1:0]     vel_b_y;
  logic [cir_pkg::VEL_W-1:0]     vel_b_z;
  logic [cir_pkg::NRM_W-1:0]     normal_x;
  logic [cir_pkg::NRM_W-1:0]     normal_y;
  logic [cir_pkg::NRM_W-1:0]     normal_z;
  logic [cir_pkg::BNC_W-1:0]     bounce;
  logic [cir_pkg::IM_W-1:0]      inv_mass_a;
  logic [cir_pkg::IM_W-1:0]      inv_mass_b;

  modport source (output valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
                  normal_x, normal_y, normal_z, bounce, inv_mass_a, inv_mass_b,
                  input ready);
  modport sink (input valid, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
                normal_x, normal_y, normal_z, bounce, inv_mass_a, inv_mass_b,
                output ready);
endinterface

@@ hw/rtl/cir_out_if.sv @@
// resolved velocity word channel
interface cir_out_if;
  logic                      valid;
  logic                      ready;
  logic [cir_pkg::VEL_W-1:0] new_vel_a_x;
  logic [cir_pkg::VEL_W-1:0] new_vel_a_y;
  logic [cir_pkg::VEL_W-1:0] new_vel_a_z;
  logic [cir_pkg::VEL_W-1:0] new_vel_b_x;
  logic [cir_pkg::VEL_W-1:0] new_vel_b_y;
  logic [cir_pkg::VEL_W-1:0] new_vel_b_z;
  logic [1:0]                outcome;

  modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
                  new_vel_b_x, new_vel_b_y, new_vel_b_z, outcome, input ready);
  modport sink (input valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
                new_vel_b_x, new_vel_b_y, new_vel_b_z, outcome, output ready);
endinterface

@@ hw/rtl/contact_impulse_resolver.sv @@
// contact impulse resolver: pipelined normal speed, divider and velocity update
//
//   channel   dir  modport  payload
//   contact   in   sink     velocities a/b, normal, bounce, inverse masses
//   result    out  source   new velocities a/b, outcome
//
// one contact per cycle sustained while results are accepted; the pipeline is the
// 54-stage one-bit-per-stage restoring divider plus 8 arithmetic stages.
// reset clears the stage valid bits only.
// a stalled result freezes the whole pipeline; nothing is dropped or repeated.
module contact_impulse_resolver (
  input  logic      clk,
  input  logic      rst,
  cir_in_if.sink    contact,
  cir_out_if.source result
);

  localparam int NS = cir_pkg::DIV_STEPS;

  logic adv;

  // stage 1: velocity differences
  logic                               v1;
  cir_pkg::ctx_t                      c1;
  logic [2:0][cir_pkg::DIFF_W-1:0]    d1;
  logic [cir_pkg::BNC_W-1:0]          e1;
  logic [cir_pkg::SUM_W-1:0]          sum1;
  // stage 2: per-axis products
  logic                               v2;
  cir_pkg::ctx_t                      c2;
  logic [2:0][cir_pkg::PROD_W-1:0]    p2;
  logic [cir_pkg::BNC_W-1:0]          e2;
  logic [cir_pkg::SUM_W-1:0]          sum2;
  // stage 3: normal speed, outcome
  logic                               v3;
  cir_pkg::ctx_t                      c3;
  logic [cir_pkg::NEG_W-1:0]          neg3;
  logic [cir_pkg::BNC_W-1:0]          e3;
  logic [cir_pkg::SUM_W-1:0]          sum3;
  logic signed [cir_pkg::VN_W-1:0]    vn_c;
  logic signed [cir_pkg::VN_W-1:0]    vnq_c;
  logic signed [cir_pkg::VN_W-1:0]    neg_c;
  // stage 4: numerator
  logic                               v4;
  cir_pkg::ctx_t                      c4;
  logic [cir_pkg::NUM_W-1:0]          num4;
  logic [cir_pkg::SUM_W-1:0]          sum4;
  // divider stages
  logic          dv   [1:NS];
  cir_pkg::ctx_t dc   [1:NS];
  logic [cir_pkg::SUM_W-1:0] drem [1:NS];
  logic [cir_pkg::NUM_W-1:0] dq   [1:NS];
  logic [cir_pkg::NUM_W-1:0] dnum [1:NS];
  logic [cir_pkg::SUM_W-1:0] dsum [1:NS];
  // stage 5: normal times impulse
  logic                               v5;
  cir_pkg::ctx_t                      c5;
  logic [2:0][cir_pkg::JP_W-1:0]      pn5;
  logic [cir_pkg::IM_W-1:0]           j_c;
  // stage 6: saturated impulse
  logic                               v6;
  cir_pkg::ctx_t                      c6;
  logic [2:0][cir_pkg::VEL_W-1:0]     imp6;
  // stage 7: velocity deltas
  logic                               v7;
  cir_pkg::ctx_t                      c7;
  logic [2:0][cir_pkg::DV_W-1:0]      da7;
  logic [2:0][cir_pkg::DV_W-1:0]      db7;
  // stage 8: output register
  logic                               v8;
  logic [2:0][cir_pkg::VEL_W-1:0]     na8;
  logic [2:0][cir_pkg::VEL_W-1:0]     nb8;
  cir_pkg::outcome_t                  oc8;

  // whole pipeline moves unless the output word is held
  assign adv = !v8 || result.ready;
  assign contact.ready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (adv) begin
      v1 <= contact.valid;
      v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= dv[NS]; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      c1.va      <= {contact.vel_a_z, contact.vel_a_y, contact.vel_a_x};
      c1.vb      <= {contact.vel_b_z, contact.vel_b_y, contact.vel_b_x};
      c1.n       <= {contact.normal_z, contact.normal_y, contact.normal_x};
      c1.ima     <= contact.inv_mass_a;
      c1.imb     <= contact.inv_mass_b;
      c1.outcome <= cir_pkg::OUT_IMPULSE;
      d1[0] <= {contact.vel_b_x[31], contact.vel_b_x} - {contact.vel_a_x[31], contact.vel_a_x};
      d1[1] <= {contact.vel_b_y[31], contact.vel_b_y} - {contact.vel_a_y[31], contact.vel_a_y};
      d1[2] <= {contact.vel_b_z[31], contact.vel_b_z} - {contact.vel_a_z[31], contact.vel_a_z};
      e1    <= contact.bounce;
      sum1  <= {1'b0, contact.inv_mass_a} + {1'b0, contact.inv_mass_b};
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      c2 <= c1; e2 <= e1; sum2 <= sum1;
      for (int i = 0; i < 3; i++) begin
        p2[i] <= cir_pkg::PROD_W'($signed(d1[i]) * $signed(c1.n[i]));
      end
    end
  end

  // stage 3: sum of products, floor to q16.16, negate
  always_comb begin
    vn_c  = $signed({{2{p2[0][cir_pkg::PROD_W-1]}}, p2[0]})
          + $signed({{2{p2[1][cir_pkg::PROD_W-1]}}, p2[1]})
          + $signed({{2{p2[2][cir_pkg::PROD_W-1]}}, p2[2]});
    vnq_c = vn_c >>> cir_pkg::FRAC;
    neg_c = -vnq_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3 <= c2;
      if (vn_c > 0) begin
        c3.outcome <= cir_pkg::OUT_SEPARATE;
      end else if (sum2 == '0) begin
        c3.outcome <= cir_pkg::OUT_STATIC;
      end else begin
        c3.outcome <= cir_pkg::OUT_IMPULSE;
      end
      neg3 <= neg_c[cir_pkg::NEG_W-1:0];
      e3   <= e2;
      sum3 <= sum2;
    end
  end

  // stage 4: numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      c4   <= c3;
      sum4 <= sum3;
      num4 <= cir_pkg::NUM_W'(neg3 * (cir_pkg::ONE_Q16 + cir_pkg::FAC_W'(e3)));
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic                      pv;
    cir_pkg::ctx_t             pc;
    logic [cir_pkg::SUM_W-1:0] prem;
    logic [cir_pkg::NUM_W-1:0] pq;
    logic [cir_pkg::NUM_W-1:0] pnum;
    logic [cir_pkg::SUM_W-1:0] psum;
    logic [cir_pkg::SUM_W:0]   trial;
    logic [cir_pkg::SUM_W:0]   diff;

    if (k == 1) begin : g_first
      assign pv = v4; assign pc = c4; assign prem = '0;
      assign pq = '0; assign pnum = num4; assign psum = sum4;
    end else begin : g_rest
      assign pv = dv[k-1]; assign pc = dc[k-1]; assign prem = drem[k-1];
      assign pq = dq[k-1]; assign pnum = dnum[k-1]; assign psum = dsum[k-1];
    end

    assign trial = {prem, pnum[cir_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, psum};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (adv) begin
        dv[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dc[k]   <= pc;
        dsum[k] <= psum;
        dnum[k] <= {pnum[cir_pkg::NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, psum}) begin
          drem[k] <= diff[cir_pkg::SUM_W-1:0];
          dq[k]   <= {pq[cir_pkg::NUM_W-2:0], 1'b1};
        end else begin
          drem[k] <= trial[cir_pkg::SUM_W-1:0];
          dq[k]   <= {pq[cir_pkg::NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // stage 5: clamp impulse, scale normal
  always_comb begin
    if (dq[NS] > cir_pkg::NUM_W'(cir_pkg::J_MAX)) begin
      j_c = cir_pkg::J_MAX;
    end else begin
      j_c = dq[NS][cir_pkg::IM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5 <= dc[NS];
      for (int i = 0; i < 3; i++) begin
        pn5[i] <= cir_pkg::JP_W'($signed(dc[NS].n[i]) * $signed({1'b0, j_c}));
      end
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (adv) begin
      c6 <= c5;
      for (int i = 0; i < 3; i++) begin
        imp6[i] <= cir_pkg::sat32(64'($signed(pn5[i]) >>> cir_pkg::FRAC));
      end
    end
  end

  // stage 7
  always_ff @(posedge clk) begin
    if (adv) begin
      c7 <= c6;
      for (int i = 0; i < 3; i++) begin
        da7[i] <= cir_pkg::DV_W'($signed(imp6[i]) * $signed({1'b0, c6.ima}));
        db7[i] <= cir_pkg::DV_W'($signed(imp6[i]) * $signed({1'b0, c6.imb}));
      end
    end
  end

  // stage 8: apply deltas or pass through
  always_ff @(posedge clk) begin
    if (adv) begin
      oc8 <= c7.outcome;
      for (int i = 0; i < 3; i++) begin
        if (c7.outcome == cir_pkg::OUT_IMPULSE) begin
          na8[i] <= cir_pkg::sat32(64'($signed(c7.va[i]))
                                   - 64'($signed(da7[i]) >>> cir_pkg::FRAC));
          nb8[i] <= cir_pkg::sat32(64'($signed(c7.vb[i]))
                                   + 64'($signed(db7[i]) >>> cir_pkg::FRAC));
        end else begin
          na8[i] <= c7.va[i];
          nb8[i] <= c7.vb[i];
        end
      end
    end
  end

  assign result.valid       = v8;
  assign result.new_vel_a_x = na8[0];
  assign result.new_vel_a_y = na8[1];
  assign result.new_vel_a_z = na8[2];
  assign result.new_vel_b_x = nb8[0];
  assign result.new_vel_b_y = nb8[1];
  assign result.new_vel_b_z = nb8[2];
  assign result.outcome     = oc8;

endmodule
